// File: hdl/ppbe_pkg.sv
// ----------------------------------------------------------------------------
// ppbe_pkg: shared types and constants for the pause-pulse bit encoder
// Holds the item kinds, the register map, the segment codes and the structs
// that travel between the register file, the core and the top level.
// ----------------------------------------------------------------------------
package ppbe_pkg;

    localparam int REG_WIDTH  = 16;
    localparam int NUM_REGS   = 8;
    localparam int ADDR_WIDTH = 5;
    localparam int APB_WIDTH  = 32;
    localparam int DATA_WIDTH = 64;
    localparam int OUT_WIDTH  = 8;

    // Item kinds carried in tuser.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_PAUSE       = 3'd0,
        REG_ONE_FIRST   = 3'd1,
        REG_ONE_SECOND  = 3'd2,
        REG_ZERO_FIRST  = 3'd3,
        REG_ZERO_SECOND = 3'd4,
        REG_ONE_END     = 3'd5,
        REG_ZERO_END    = 3'd6,
        REG_QUIET       = 3'd7
    } t_reg_idx;

    localparam logic [REG_WIDTH-1:0] RST_PAUSE       = 16'd40;
    localparam logic [REG_WIDTH-1:0] RST_ONE_FIRST   = 16'd100;
    localparam logic [REG_WIDTH-1:0] RST_ONE_SECOND  = 16'd60;
    localparam logic [REG_WIDTH-1:0] RST_ZERO_FIRST  = 16'd60;
    localparam logic [REG_WIDTH-1:0] RST_ZERO_SECOND = 16'd100;
    localparam logic [REG_WIDTH-1:0] RST_ONE_END     = 16'd120;
    localparam logic [REG_WIDTH-1:0] RST_ZERO_END    = 16'd160;
    localparam logic [REG_WIDTH-1:0] RST_QUIET       = 16'd2000;

    // Segments of one bit, plus the quiet gap after each pass over the frame.
    typedef enum logic [2:0] {
        SEG_PAUSE_A = 3'd0,
        SEG_FIRST   = 3'd1,
        SEG_PAUSE_B = 3'd2,
        SEG_SECOND  = 3'd3,
        SEG_QUIET   = 3'd4
    } t_seg;

    typedef struct packed {
        logic [REG_WIDTH-1:0] pause;
        logic [REG_WIDTH-1:0] bit1_first;
        logic [REG_WIDTH-1:0] bit1_second;
        logic [REG_WIDTH-1:0] bit0_first;
        logic [REG_WIDTH-1:0] bit0_second;
        logic [REG_WIDTH-1:0] bit1_end;
        logic [REG_WIDTH-1:0] bit0_end;
        logic [REG_WIDTH-1:0] quiet;
    } t_cfg;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_result;

endpackage

// File: hdl/ppbe_regs.sv
// ----------------------------------------------------------------------------
// ppbe_regs: configuration register file
// Eight 16-bit timing registers behind an APB-style port with zero wait states.
// ----------------------------------------------------------------------------
module ppbe_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppbe_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [ppbe_pkg::APB_WIDTH-1:0]     pwdata,
    output logic [ppbe_pkg::APB_WIDTH-1:0]     prdata,
    output logic                               pready,
    output ppbe_pkg::t_cfg                     o_cfg
);

    logic [ppbe_pkg::REG_WIDTH-1:0] r_regs [ppbe_pkg::NUM_REGS];
    ppbe_pkg::t_reg_idx             idx;
    logic                           wr_en;

    assign idx    = ppbe_pkg::t_reg_idx'(paddr[ppbe_pkg::ADDR_WIDTH-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[ppbe_pkg::REG_PAUSE]       <= ppbe_pkg::RST_PAUSE;
            r_regs[ppbe_pkg::REG_ONE_FIRST]   <= ppbe_pkg::RST_ONE_FIRST;
            r_regs[ppbe_pkg::REG_ONE_SECOND]  <= ppbe_pkg::RST_ONE_SECOND;
            r_regs[ppbe_pkg::REG_ZERO_FIRST]  <= ppbe_pkg::RST_ZERO_FIRST;
            r_regs[ppbe_pkg::REG_ZERO_SECOND] <= ppbe_pkg::RST_ZERO_SECOND;
            r_regs[ppbe_pkg::REG_ONE_END]     <= ppbe_pkg::RST_ONE_END;
            r_regs[ppbe_pkg::REG_ZERO_END]    <= ppbe_pkg::RST_ZERO_END;
            r_regs[ppbe_pkg::REG_QUIET]       <= ppbe_pkg::RST_QUIET;
        end else if (wr_en) begin
            r_regs[idx] <= pwdata[ppbe_pkg::REG_WIDTH-1:0];
        end
    end

    assign prdata = {{(ppbe_pkg::APB_WIDTH - ppbe_pkg::REG_WIDTH){1'b0}}, r_regs[idx]};

    assign o_cfg.pause       = r_regs[ppbe_pkg::REG_PAUSE];
    assign o_cfg.bit1_first  = r_regs[ppbe_pkg::REG_ONE_FIRST];
    assign o_cfg.bit1_second = r_regs[ppbe_pkg::REG_ONE_SECOND];
    assign o_cfg.bit0_first  = r_regs[ppbe_pkg::REG_ZERO_FIRST];
    assign o_cfg.bit0_second = r_regs[ppbe_pkg::REG_ZERO_SECOND];
    assign o_cfg.bit1_end    = r_regs[ppbe_pkg::REG_ONE_END];
    assign o_cfg.bit0_end    = r_regs[ppbe_pkg::REG_ZERO_END];
    assign o_cfg.quiet       = r_regs[ppbe_pkg::REG_QUIET];

endmodule

// File: hdl/ppbe_core.sv
// ----------------------------------------------------------------------------
// ppbe_core: segment sequencer
// Holds the frame, the bit, segment and repetition counters, and turns one
// registered request per cycle into the line level for that carrier cycle.
// ----------------------------------------------------------------------------
module ppbe_core #(
    parameter int FRAME_BITS  = 64,
    parameter int REPEATS     = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_kind,
    input  logic [ppbe_pkg::DATA_WIDTH-1:0]     i_frame_data,
    input  ppbe_pkg::t_cfg                      i_cfg,
    output ppbe_pkg::t_result                   o_result
);

    localparam int BW        = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam int RW        = (REPEATS > 1) ? $clog2(REPEATS) : 1;
    localparam int SENT_BITS = (FRAME_BITS / 8) * 8;
    localparam int EXT_W     = (COUNT_WIDTH > ppbe_pkg::REG_WIDTH) ?
                               COUNT_WIDTH : ppbe_pkg::REG_WIDTH;
    localparam logic [BW-1:0]          LAST_BIT  = BW'(SENT_BITS - 1);
    localparam logic [RW-1:0]          LAST_REP  = RW'(REPEATS - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [FRAME_BITS-1:0]  r_frame, n_frame;
    logic [RW-1:0]          r_rep, n_rep;
    logic [BW-1:0]          r_bit, n_bit;
    ppbe_pkg::t_seg         r_seg, n_seg;
    logic [COUNT_WIDTH-1:0] r_left, n_left;
    logic                   r_active, n_active;

    logic                   bit_one;
    logic                   bit_last;
    logic [COUNT_WIDTH-1:0] left_dec;
    logic                   seg_end;
    logic                   is_start;
    logic                   is_tick;

    // Zero counts as one cycle; values above the counter range saturate.
    function automatic logic [COUNT_WIDTH-1:0] clamp_count(
        input logic [ppbe_pkg::REG_WIDTH-1:0] v
    );
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (v == '0) begin
            return COUNT_WIDTH'(1);
        end else if (ext > EXT_W'(COUNT_MAX)) begin
            return COUNT_MAX;
        end else begin
            return COUNT_WIDTH'(ext);
        end
    endfunction

    // Length of a segment for the current bit. A new bit always starts with
    // a pause, so the bit-dependent segments only ever need the current bit.
    function automatic logic [COUNT_WIDTH-1:0] seg_len(
        input ppbe_pkg::t_seg s,
        input logic           one,
        input logic           last,
        input ppbe_pkg::t_cfg c
    );
        logic [ppbe_pkg::REG_WIDTH-1:0] v;
        case (s)
            ppbe_pkg::SEG_PAUSE_A,
            ppbe_pkg::SEG_PAUSE_B: v = c.pause;
            ppbe_pkg::SEG_FIRST:   v = one ? c.bit1_first : c.bit0_first;
            ppbe_pkg::SEG_SECOND: begin
                if (last) begin
                    v = one ? c.bit1_end : c.bit0_end;
                end else begin
                    v = one ? c.bit1_second : c.bit0_second;
                end
            end
            default:               v = c.quiet;
        endcase
        return clamp_count(v);
    endfunction

    assign bit_one  = r_frame[r_bit];
    assign bit_last = (r_bit[2:0] == 3'd7);
    assign left_dec = r_left - COUNT_WIDTH'(1);
    assign seg_end  = (left_dec == '0);
    assign is_start = i_step && (i_kind == ppbe_pkg::KIND_START);
    assign is_tick  = i_step && (i_kind == ppbe_pkg::KIND_TICK);

    // Next state.
    always_comb begin
        n_frame  = r_frame;
        n_rep    = r_rep;
        n_bit    = r_bit;
        n_seg    = r_seg;
        n_left   = r_left;
        n_active = r_active;
        if (is_start && !r_active) begin
            n_frame  = i_frame_data[FRAME_BITS-1:0];
            n_rep    = '0;
            n_bit    = '0;
            n_active = 1'b1;
            n_seg    = ppbe_pkg::SEG_PAUSE_A;
            n_left   = seg_len(ppbe_pkg::SEG_PAUSE_A, 1'b0, 1'b0, i_cfg);
        end else if (is_tick && r_active) begin
            n_left = left_dec;
            if (seg_end) begin
                unique case (r_seg)
                    ppbe_pkg::SEG_PAUSE_A: begin
                        n_seg  = ppbe_pkg::SEG_FIRST;
                        n_left = seg_len(ppbe_pkg::SEG_FIRST, bit_one, bit_last, i_cfg);
                    end
                    ppbe_pkg::SEG_FIRST: begin
                        n_seg  = ppbe_pkg::SEG_PAUSE_B;
                        n_left = seg_len(ppbe_pkg::SEG_PAUSE_B, bit_one, bit_last, i_cfg);
                    end
                    ppbe_pkg::SEG_PAUSE_B: begin
                        n_seg  = ppbe_pkg::SEG_SECOND;
                        n_left = seg_len(ppbe_pkg::SEG_SECOND, bit_one, bit_last, i_cfg);
                    end
                    ppbe_pkg::SEG_SECOND: begin
                        if (r_bit != LAST_BIT) begin
                            n_bit  = r_bit + BW'(1);
                            n_seg  = ppbe_pkg::SEG_PAUSE_A;
                            n_left = seg_len(ppbe_pkg::SEG_PAUSE_A, bit_one, bit_last, i_cfg);
                        end else begin
                            n_seg  = ppbe_pkg::SEG_QUIET;
                            n_left = seg_len(ppbe_pkg::SEG_QUIET, bit_one, bit_last, i_cfg);
                        end
                    end
                    default: begin
                        n_bit = '0;
                        if (r_rep == LAST_REP) begin
                            n_active = 1'b0;
                            n_rep    = '0;
                            n_seg    = ppbe_pkg::SEG_PAUSE_A;
                            n_left   = '0;
                        end else begin
                            n_rep  = r_rep + RW'(1);
                            n_seg  = ppbe_pkg::SEG_PAUSE_A;
                            n_left = seg_len(ppbe_pkg::SEG_PAUSE_A, bit_one, bit_last, i_cfg);
                        end
                    end
                endcase
            end
        end
    end

    // Result for the request being processed this cycle.
    always_comb begin
        o_result = '0;
        if (is_start) begin
            o_result.busy_res = 1'b1;
        end else if (is_tick && r_active) begin
            o_result.busy_res   = 1'b1;
            o_result.line_level = (r_seg == ppbe_pkg::SEG_PAUSE_A) ||
                                  (r_seg == ppbe_pkg::SEG_PAUSE_B);
            o_result.frame_done = seg_end && (r_seg == ppbe_pkg::SEG_QUIET) &&
                                  (r_rep == LAST_REP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame  <= '0;
            r_rep    <= '0;
            r_bit    <= '0;
            r_seg    <= ppbe_pkg::SEG_PAUSE_A;
            r_left   <= '0;
            r_active <= 1'b0;
        end else begin
            r_frame  <= n_frame;
            r_rep    <= n_rep;
            r_bit    <= n_bit;
            r_seg    <= n_seg;
            r_left   <= n_left;
            r_active <= n_active;
        end
    end

endmodule

// File: hdl/pause_pulse_bit_encoder.sv
// ----------------------------------------------------------------------------
// pause_pulse_bit_encoder: pulse interval encoder, top level
// Input register, segment sequencer, result register and register file.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result side keeps up, and
// returns one result for each; a request is held in the input register and
// its result in the result register. Every tick request is one carrier
// cycle, and the segment sequencer updates its cycle counter, bit position
// and repetition count in that single cycle, so a tick can follow the
// previous one on the next clock. While a result waits in the result register,
// one more request is taken into the input register, and the input then stalls
// until the waiting result is taken.
// ----------------------------------------------------------------------------
module pause_pulse_bit_encoder #(
    parameter int FRAME_BITS  = 64,
    parameter int REPEATS     = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [ppbe_pkg::DATA_WIDTH-1:0]     i_s_axis_tdata,  // [63:0] frame_data
    input  logic                                i_s_axis_tuser,  // [0] kind
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [ppbe_pkg::OUT_WIDTH-1:0]      o_m_axis_tdata,  // [0] line_level, [1] busy_res
    output logic                                o_m_axis_tlast,  // frame_done
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppbe_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [ppbe_pkg::APB_WIDTH-1:0]      pwdata,
    output logic [ppbe_pkg::APB_WIDTH-1:0]      prdata,
    output logic                                pready
);

    logic                              r_in_valid;
    logic                              r_in_kind;
    logic [ppbe_pkg::DATA_WIDTH-1:0]   r_in_data;
    logic                              r_out_valid;
    ppbe_pkg::t_result                 r_out;
    ppbe_pkg::t_result                 core_result;
    ppbe_pkg::t_cfg                    cfg;
    logic                              advance;
    logic                              in_fire;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    ppbe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppbe_core #(
        .FRAME_BITS  (FRAME_BITS),
        .REPEATS     (REPEATS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_kind       (r_in_kind),
        .i_frame_data (r_in_data),
        .i_cfg        (cfg),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_kind <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(ppbe_pkg::OUT_WIDTH - 2){1'b0}}, r_out.busy_res,
                              r_out.line_level};
    assign o_m_axis_tlast  = r_out.frame_done;

endmodule

// File: dv/ppbe_level_checker.sv
// ----------------------------------------------------------------------------
// ppbe_level_checker: result checker for the pause-pulse bit encoder
// Watches the request, result and register channels. It keeps its own copy of
// the timing registers and of the segment sequencer, works out the line level,
// busy flag and frame-done flag for every accepted request, and compares them
// with the results in order.
// ----------------------------------------------------------------------------
module ppbe_level_checker
    import ppbe_pkg::*;
#(
    parameter int FRAME_BITS = 64,
    parameter int REPEATS    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [DATA_WIDTH-1:0] i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_WIDTH-1:0]  i_m_tdata,
    input  logic                  i_m_tlast,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [ADDR_WIDTH-1:0] i_paddr,
    input  logic [APB_WIDTH-1:0]  i_pwdata,
    input  logic                  i_pready,
    output int                    o_errors,
    output int                    o_pending,
    output logic                  o_active
);

    // Only whole bytes go out on the line.
    localparam int LAST_BIT = (FRAME_BITS / 8) * 8 - 1;

    logic [REG_WIDTH-1:0]  timing [NUM_REGS];
    logic [DATA_WIDTH-1:0] frame_bits;
    logic [2:0]            pass_cnt;
    logic [5:0]            bit_pos;
    t_seg                  seg;
    logic [REG_WIDTH-1:0]  seg_left;
    logic                  sending;
    t_result               levels_due [$];
    int                    err_cnt = 0;

    function automatic logic [REG_WIDTH-1:0] seg_span(t_seg s);
        logic                 one;
        logic                 end_of_byte;
        logic [REG_WIDTH-1:0] v;
        one         = frame_bits[bit_pos];
        end_of_byte = (bit_pos[2:0] == 3'd7);
        case (s)
            SEG_PAUSE_A, SEG_PAUSE_B: begin
                v = timing[REG_PAUSE];
            end
            SEG_FIRST: begin
                v = one ? timing[REG_ONE_FIRST] : timing[REG_ZERO_FIRST];
            end
            SEG_SECOND: begin
                if (end_of_byte) begin
                    v = one ? timing[REG_ONE_END] : timing[REG_ZERO_END];
                end else begin
                    v = one ? timing[REG_ONE_SECOND] : timing[REG_ZERO_SECOND];
                end
            end
            default: begin
                v = timing[REG_QUIET];
            end
        endcase
        // A zero count still lasts one carrier cycle.
        return (v == '0) ? REG_WIDTH'(1) : v;
    endfunction

    task automatic enter_seg(input t_seg s);
        seg      = s;
        seg_left = seg_span(s);
    endtask

    task automatic encode_item(input logic kind, input logic [DATA_WIDTH-1:0] data,
                               output t_result r);
        r = '0;
        if (kind == KIND_START) begin
            if (!sending) begin
                frame_bits = data;
                pass_cnt   = '0;
                bit_pos    = '0;
                sending    = 1'b1;
                enter_seg(SEG_PAUSE_A);
            end
            r.busy_res = sending;
        end else if (sending) begin
            r.busy_res   = 1'b1;
            r.line_level = (seg == SEG_PAUSE_A) || (seg == SEG_PAUSE_B);
            seg_left     = seg_left - 1'b1;
            if (seg_left == '0) begin
                case (seg)
                    SEG_PAUSE_A, SEG_FIRST, SEG_PAUSE_B: begin
                        enter_seg(t_seg'(seg + 1'b1));
                    end
                    SEG_SECOND: begin
                        if (bit_pos != 6'(LAST_BIT)) begin
                            bit_pos = bit_pos + 1'b1;
                            enter_seg(SEG_PAUSE_A);
                        end else begin
                            enter_seg(SEG_QUIET);
                        end
                    end
                    default: begin
                        pass_cnt = pass_cnt + 1'b1;
                        if (pass_cnt >= REPEATS) begin
                            sending      = 1'b0;
                            r.frame_done = 1'b1;
                            pass_cnt     = '0;
                            bit_pos      = '0;
                            seg          = SEG_PAUSE_A;
                            seg_left     = '0;
                        end else begin
                            bit_pos = '0;
                            enter_seg(SEG_PAUSE_A);
                        end
                    end
                endcase
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result due;
        if (!i_rst_n) begin
            timing[REG_PAUSE]       = RST_PAUSE;
            timing[REG_ONE_FIRST]   = RST_ONE_FIRST;
            timing[REG_ONE_SECOND]  = RST_ONE_SECOND;
            timing[REG_ZERO_FIRST]  = RST_ZERO_FIRST;
            timing[REG_ZERO_SECOND] = RST_ZERO_SECOND;
            timing[REG_ONE_END]     = RST_ONE_END;
            timing[REG_ZERO_END]    = RST_ZERO_END;
            timing[REG_QUIET]       = RST_QUIET;
            frame_bits = '0;
            pass_cnt   = '0;
            bit_pos    = '0;
            seg        = SEG_PAUSE_A;
            seg_left   = '0;
            sending    = 1'b0;
            levels_due.delete();
        end else begin
            // Results leave only after their request has passed the input register,
            // so the compare runs before the prediction for this edge's request.
            if (i_m_tvalid && i_m_tready) begin
                got.line_level = i_m_tdata[0];
                got.busy_res   = i_m_tdata[1];
                got.frame_done = i_m_tlast;
                if (levels_due.size() == 0) begin
                    $error("result with no request waiting: level %0b busy %0b done %0b",
                           got.line_level, got.busy_res, got.frame_done);
                    err_cnt++;
                end else begin
                    want = levels_due.pop_front();
                    if (got.line_level !== want.line_level) begin
                        $error("line_level: expected %0b, got %0b",
                               want.line_level, got.line_level);
                        err_cnt++;
                    end
                    if (got.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0b, got %0b",
                               want.busy_res, got.busy_res);
                        err_cnt++;
                    end
                    if (got.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b",
                               want.frame_done, got.frame_done);
                        err_cnt++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                encode_item(i_s_tuser, i_s_tdata, due);
                levels_due.push_back(due);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                timing[i_paddr[ADDR_WIDTH-1:2]] = i_pwdata[REG_WIDTH-1:0];
            end
        end
        o_errors  <= err_cnt;
        o_pending <= levels_due.size();
        o_active  <= sending;
    end

endmodule

// File: dv/pause_pulse_bit_encoder_test.sv
// ----------------------------------------------------------------------------
// pause_pulse_bit_encoder_test: top of the encoder testbench
// Drives tick and start requests and register writes, stalls the result side,
// and gives the verdict from the failure count of the checker beside the block.
// One frame starts at the reset timing, is retimed to short random counts with
// zeros among them, and finishes all its repetitions at the shortest counts.
// ----------------------------------------------------------------------------
module pause_pulse_bit_encoder_test;
    import ppbe_pkg::*;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [DATA_WIDTH-1:0] i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = KIND_TICK;
    logic                  i_m_axis_tready = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr           = '0;
    logic [APB_WIDTH-1:0]  pwdata          = '0;

    wire                   o_s_axis_tready;
    wire                   o_m_axis_tvalid;
    wire  [OUT_WIDTH-1:0]  o_m_axis_tdata;
    wire                   o_m_axis_tlast;
    wire  [APB_WIDTH-1:0]  prdata;
    wire                   pready;

    int   chk_errors;
    int   chk_pending;
    logic chk_active;

    bit idle_on  = 1'b0;
    bit hold_req = 1'b0;

    pause_pulse_bit_encoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [63:0] frame_data
        .i_s_axis_tuser  (i_s_axis_tuser),   // [0] kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [0] line_level, [1] busy_res
        .o_m_axis_tlast  (o_m_axis_tlast),   // frame_done
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    ppbe_level_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_m_tdata  (o_m_axis_tdata),
        .i_m_tlast  (o_m_axis_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_active   (chk_active)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [REG_WIDTH-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r < 8) begin
            return REG_WIDTH'($urandom_range(1, 4));
        end
        return REG_WIDTH'($urandom_range(5, 12));
    endfunction

    // Leaves tvalid high on return so that the next request can follow at once.
    task automatic send_item(input logic kind, input logic [DATA_WIDTH-1:0] data);
        int gap;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    // psel stays high across back-to-back writes; each one has its own setup.
    task automatic write_reg(input t_reg_idx idx, input logic [REG_WIDTH-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= {16'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic write_timing(input logic [REG_WIDTH-1:0] vals [NUM_REGS]);
        settle();
        repeat (4) @(posedge i_clk);
        for (int i = 0; i < NUM_REGS; i++) begin
            write_reg(t_reg_idx'(i), vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends n requests while a frame is under way. A start mixed in now and
    // then arrives while the encoder is busy and must be dropped.
    task automatic send_ticks(input int n, input int start_odds);
        logic kind;
        for (int k = 0; k < n; k++) begin
            kind = (start_odds > 0 && $urandom_range(1, start_odds) == 1)
                   ? KIND_START : KIND_TICK;
            send_item(kind, {$urandom, $urandom});
        end
    endtask

    // Keeps ticking until all repetitions are out and every result is back.
    task automatic finish_frame();
        while (1) begin
            if (chk_active) begin
                send_item(KIND_TICK, {$urandom, $urandom});
            end else begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                if (!chk_active && chk_pending == 0) break;
            end
        end
    endtask

    initial begin : receiver
        bit held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                // One long hold-off so the block backs up into its input.
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [REG_WIDTH-1:0]  vals [NUM_REGS];
        logic [DATA_WIDTH-1:0] frame_val;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ticks while idle.
        send_item(KIND_TICK, '1);
        send_item(KIND_TICK, '0);

        // Start at the reset timing; the second start comes while busy.
        frame_val = {$urandom, $urandom};
        send_item(KIND_START, frame_val);
        send_item(KIND_START, ~frame_val);
        send_ticks(44, 0);

        // Retime in the middle of the frame to short counts with zeros among
        // them, with random gaps and one long stall on the result side.
        foreach (vals[i]) vals[i] = pick_count();
        write_timing(vals);
        idle_on  = 1'b1;
        hold_req = 1'b1;
        send_ticks(100, 30);

        // Shortest counts for the rest of the frame. The end-of-byte times
        // stay longer so that their selection shows on the line.
        foreach (vals[i]) vals[i] = REG_WIDTH'($urandom_range(0, 1));
        vals[REG_ONE_END]  = REG_WIDTH'(2);
        vals[REG_ZERO_END] = REG_WIDTH'(2);
        vals[REG_QUIET]    = REG_WIDTH'($urandom_range(0, 3));
        write_timing(vals);
        finish_frame();

        // Ticks once the encoder is idle again.
        repeat (4) send_item(KIND_TICK, {$urandom, $urandom});

        settle();
        repeat (8) @(posedge i_clk);
        if (chk_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
